@@ src/ctr_pkg.sv @@
// shared constants and codes for the cosine top-k recall block
`timescale 1ns / 1ps
package ctr_pkg;

  localparam int ENTRIES      = 256;
  localparam int MAX_LENGTH   = 64;
  localparam int MAX_TOP_K    = 16;
  localparam int ELEMENT_BITS = 16;

  localparam int ENTRY_AW = $clog2(ENTRIES);
  localparam int TOTAL_W  = $clog2(ENTRIES + 1);
  localparam int LEN_AW   = $clog2(MAX_LENGTH);
  localparam int KEY_AW   = ENTRY_AW + LEN_AW;
  localparam int KEY_DEPTH = ENTRIES * MAX_LENGTH;

  localparam int POS_W    = 7;
  localparam int TOPK_W   = 5;
  localparam int IDX_W    = 8;
  localparam int RANK_W   = 4;
  localparam int STAT_W   = 3;
  localparam int CONF_W   = 16;
  localparam int WGT_W    = 16;
  localparam int SCORE_W  = 32;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 32;

  localparam int PROD_W   = 2 * ELEMENT_BITS;
  localparam int NORM_W   = 37;
  localparam int DOT_W    = 38;
  localparam int ROOT_W   = 29;
  localparam int SQX_W    = 58;
  localparam int SQR_W    = 32;
  localparam int MUL_W    = 58;
  localparam int DIVN_W   = 81;
  localparam int DIVR_W   = 59;
  localparam int QUO_W    = 64;
  localparam int QC_W     = 41;
  localparam int STEP_W   = 7;

  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DMUL_STEPS = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(DIVN_W - 1);
  localparam logic [STEP_W-1:0] WMUL_STEPS = STEP_W'(WGT_W - 1);

  localparam logic [TOPK_W-1:0]  KMAX      = TOPK_W'(MAX_TOP_K);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(ENTRIES);
  localparam logic [POS_W-1:0]   POS_SAT   = 7'd127;
  localparam logic [POS_W-1:0]   LEN_MAX   = POS_W'(MAX_LENGTH);

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_LEN_ERR = 3'd2,
    ST_HIT     = 3'd3,
    ST_NO_HIT  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  localparam logic [CFG_IW-1:0] REG_VLEN  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TOPK  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_THR   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FLOOR = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VEN   = 3'd4;

endpackage

@@ src/ctr_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ctr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/cosine_topk_recall_core.sv @@
// cosine similarity key store with top-k search, top level
// store, clear, length error: result next cycle, one request per cycle while not stalled
// non-final elements: one request per cycle while not stalled, no result
// query end: each entry is scored with the serial sqrt, shift-add multiply and restoring
// divide, then top_k selection rounds scan the stored scores
// sync reset clears control, presets config; store contents undefined until written
`timescale 1ns / 1ps
module cosine_topk_recall_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic signed [ctr_pkg::ELEMENT_BITS-1:0] in_element,
  input  logic                                 in_last,
  input  logic signed [ctr_pkg::WGT_W-1:0]     in_weight,
  input  logic [ctr_pkg::CONF_W-1:0]           in_confidence,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ctr_pkg::STAT_W-1:0]           out_status,
  output logic [ctr_pkg::IDX_W-1:0]            out_entry_index,
  output logic signed [ctr_pkg::SCORE_W-1:0]   out_score,
  output logic [ctr_pkg::CONF_W-1:0]           out_entry_confidence,
  output logic [ctr_pkg::RANK_W-1:0]           out_rank,
  output logic                                 out_run_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctr_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [ctr_pkg::CFG_DW-1:0]           cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RQ, S_DOT, S_RK, S_MUL, S_DIV, S_WMUL, S_WR,
    S_SCAN, S_PICK, S_CONF, S_HIT, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [ctr_pkg::POS_W-1:0]          vlen_r;
  logic [ctr_pkg::TOPK_W-1:0]         topk_r;
  logic signed [ctr_pkg::SCORE_W-1:0] thr_r;
  logic [ctr_pkg::CONF_W-1:0]         floor_r;
  logic                               ven_r;

  // streaming state
  logic [ctr_pkg::POS_W-1:0]   pos_r;
  logic                        kind_r;
  logic [ctr_pkg::TOTAL_W-1:0] total_r;
  logic [ctr_pkg::NORM_W-1:0]  sqacc_r;
  logic [ctr_pkg::NORM_W-1:0]  nq_r;

  // output register and pending hit
  logic                               out_valid_r;
  logic [ctr_pkg::STAT_W-1:0]         out_status_r;
  logic [ctr_pkg::IDX_W-1:0]          out_idx_r;
  logic signed [ctr_pkg::SCORE_W-1:0] out_score_r;
  logic [ctr_pkg::CONF_W-1:0]         out_conf_r;
  logic [ctr_pkg::RANK_W-1:0]         out_rank_r;
  logic                               out_end_r;
  logic                               pend_valid_r;
  logic [ctr_pkg::IDX_W-1:0]          pend_idx_r;
  logic signed [ctr_pkg::SCORE_W-1:0] pend_score_r;
  logic [ctr_pkg::CONF_W-1:0]         pend_conf_r;
  logic [ctr_pkg::RANK_W-1:0]         pend_rank_r;

  // scoring datapath
  logic [ctr_pkg::TOTAL_W-1:0]        e_r;
  logic [ctr_pkg::POS_W-1:0]          dot_i_r;
  logic                               d1_v_r;
  logic                               d2_v_r;
  logic signed [ctr_pkg::PROD_W-1:0]  prod_r;
  logic signed [ctr_pkg::DOT_W-1:0]   dot_r;
  logic                               neg_r;
  logic [ctr_pkg::WGT_W-1:0]          wabs_r;
  logic [ctr_pkg::ROOT_W-1:0]         rq_r;
  logic [ctr_pkg::STEP_W-1:0]         step_r;
  logic [ctr_pkg::SQX_W-1:0]          sq_x_r;
  logic [ctr_pkg::SQR_W-1:0]          sq_rem_r;
  logic [ctr_pkg::ROOT_W-1:0]         sq_root_r;
  logic [ctr_pkg::MUL_W-1:0]          mu_acc_r;
  logic [ctr_pkg::MUL_W-1:0]          mu_a_r;
  logic [ctr_pkg::ROOT_W-1:0]         mu_b_r;
  logic [ctr_pkg::MUL_W-1:0]          d_r;
  logic [ctr_pkg::DIVN_W-1:0]         dv_n_r;
  logic [ctr_pkg::DIVR_W-1:0]         dv_r_r;
  logic [ctr_pkg::QUO_W-1:0]          dv_q_r;
  logic signed [ctr_pkg::SCORE_W-1:0] score_r;

  // selection, picks follow descending score then ascending index
  logic [ctr_pkg::TOPK_W-1:0]         kmax_r;
  logic [ctr_pkg::TOPK_W-1:0]         round_r;
  logic [ctr_pkg::TOPK_W-1:0]         cnt_r;
  logic [ctr_pkg::TOTAL_W-1:0]        scan_i_r;
  logic                               scan_v_r;
  logic [ctr_pkg::ENTRY_AW-1:0]       scan_didx_r;
  logic                               found_r;
  logic [ctr_pkg::ENTRY_AW-1:0]       best_r;
  logic signed [ctr_pkg::SCORE_W-1:0] best_score_r;
  logic [ctr_pkg::ENTRY_AW-1:0]       last_idx_r;
  logic signed [ctr_pkg::SCORE_W-1:0] last_score_r;

  // ram ports
  logic                               key_we, qb_we, ent_we, sc_we;
  logic [ctr_pkg::KEY_AW-1:0]         key_waddr, key_raddr;
  logic [ctr_pkg::LEN_AW-1:0]         qb_waddr, qb_raddr;
  logic [ctr_pkg::ENTRY_AW-1:0]       ent_waddr, ent_raddr, conf_raddr, sc_raddr;
  logic [ctr_pkg::ELEMENT_BITS-1:0]   key_rd, qb_rd;
  logic [ctr_pkg::WGT_W-1:0]          wgt_rd;
  logic [ctr_pkg::CONF_W-1:0]         conf_rd;
  logic [ctr_pkg::NORM_W-1:0]         norm_rd;
  logic [ctr_pkg::SCORE_W-1:0]        sc_rd;

  // request decode
  logic                               slot_free, in_acc, restart, stored, full, len_bad;
  logic [ctr_pkg::POS_W-1:0]          pos_eff, pos_inc;
  logic signed [ctr_pkg::PROD_W-1:0]  el_sq;
  logic [ctr_pkg::NORM_W-1:0]         sum_nxt;

  // unit steps
  logic [ctr_pkg::SQR_W-1:0]          sq_rem_s, sq_trial, sq_rem_nxt;
  logic [ctr_pkg::ROOT_W-1:0]         sq_root_nxt;
  logic                               sq_ge;
  logic [ctr_pkg::MUL_W-1:0]          mu_acc_nxt;
  logic [ctr_pkg::DIVR_W-1:0]         dv_rs, dv_r_nxt;
  logic                               dv_ge;
  logic [ctr_pkg::QUO_W-1:0]          dv_q_nxt;
  logic [ctr_pkg::NORM_W-1:0]         dot_mag;
  logic [ctr_pkg::QC_W-1:0]           q_clamp;
  logic [ctr_pkg::MUL_W-13:0]         wmag;
  logic signed [ctr_pkg::SCORE_W-1:0] score_nxt;
  logic signed [ctr_pkg::PROD_W-1:0]  prod_nxt;
  logic [ctr_pkg::WGT_W-1:0]          wabs_nxt;
  logic [ctr_pkg::TOPK_W-1:0]         kmax_nxt;
  logic                               round_last, e_last, dot_done, scan_done, better;
  logic                               eligible;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_score = out_score_r;
  assign out_entry_confidence = out_conf_r;
  assign out_rank = out_rank_r;
  assign out_run_end = out_end_r;

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    in_stall  = !((state_r == S_IDLE) && slot_free);
    in_acc    = in_valid && !in_stall;
    restart   = (pos_r != '0) && (kind_r != in_op[0]);
    pos_eff   = restart ? '0 : pos_r;
    stored    = (pos_eff < vlen_r) && (pos_eff < ctr_pkg::LEN_MAX);
    pos_inc   = (pos_eff < ctr_pkg::POS_SAT) ? pos_eff + 1'b1 : ctr_pkg::POS_SAT;
    len_bad   = (pos_inc != vlen_r) || (vlen_r > ctr_pkg::LEN_MAX);
    full      = (total_r == ctr_pkg::TOTAL_MAX);
    el_sq     = in_element * in_element;
    sum_nxt   = ((pos_eff == '0) ? '0 : sqacc_r)
              + (stored ? ctr_pkg::NORM_W'(unsigned'(el_sq)) : '0);

    key_we    = in_acc && (in_op == ctr_pkg::OP_STORE) && stored && !full;
    qb_we     = in_acc && (in_op == ctr_pkg::OP_QUERY) && stored;
    ent_we    = in_acc && (in_op == ctr_pkg::OP_STORE) && in_last && !len_bad && !full;
    key_waddr = {total_r[ctr_pkg::ENTRY_AW-1:0], pos_eff[ctr_pkg::LEN_AW-1:0]};
    qb_waddr  = pos_eff[ctr_pkg::LEN_AW-1:0];
    ent_waddr = total_r[ctr_pkg::ENTRY_AW-1:0];
    key_raddr = {e_r[ctr_pkg::ENTRY_AW-1:0], dot_i_r[ctr_pkg::LEN_AW-1:0]};
    qb_raddr  = dot_i_r[ctr_pkg::LEN_AW-1:0];
    ent_raddr = e_r[ctr_pkg::ENTRY_AW-1:0];
    conf_raddr = best_r;
    sc_we     = (state_r == S_WR);
    sc_raddr  = scan_i_r[ctr_pkg::ENTRY_AW-1:0];

    sq_rem_s    = {sq_rem_r[ctr_pkg::SQR_W-3:0], sq_x_r[ctr_pkg::SQX_W-1 -: 2]};
    sq_trial    = {1'b0, sq_root_r, 2'b01};
    sq_ge       = sq_rem_s >= sq_trial;
    sq_rem_nxt  = sq_ge ? sq_rem_s - sq_trial : sq_rem_s;
    sq_root_nxt = {sq_root_r[ctr_pkg::ROOT_W-2:0], sq_ge};

    mu_acc_nxt = mu_acc_r + (mu_b_r[0] ? mu_a_r : '0);

    dv_rs    = {dv_r_r[ctr_pkg::DIVR_W-2:0], dv_n_r[ctr_pkg::DIVN_W-1]};
    dv_ge    = dv_rs >= {1'b0, d_r};
    dv_r_nxt = dv_ge ? dv_rs - {1'b0, d_r} : dv_rs;
    dv_q_nxt = {dv_q_r[ctr_pkg::QUO_W-2:0], dv_ge};

    dot_mag  = dot_r[ctr_pkg::DOT_W-1] ? ctr_pkg::NORM_W'(-dot_r) : ctr_pkg::NORM_W'(dot_r);
    q_clamp  = (dv_q_nxt > (ctr_pkg::QUO_W'(1) << 40)) ? (ctr_pkg::QC_W'(1) << 40)
                                                       : dv_q_nxt[ctr_pkg::QC_W-1:0];
    wmag     = mu_acc_nxt[ctr_pkg::MUL_W-1:12];
    if (neg_r) begin
      score_nxt = (wmag > (ctr_pkg::MUL_W'(1) << 31)) ? 32'sh8000_0000
                                                      : -$signed(wmag[31:0]);
    end else begin
      score_nxt = (wmag > ctr_pkg::MUL_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                          : $signed(wmag[31:0]);
    end

    prod_nxt   = $signed(qb_rd) * $signed(key_rd);
    wabs_nxt   = wgt_rd[ctr_pkg::WGT_W-1] ? (~wgt_rd + 1'b1) : wgt_rd;
    kmax_nxt   = (topk_r > ctr_pkg::KMAX) ? ctr_pkg::KMAX : topk_r;
    round_last = (ctr_pkg::TOPK_W'(round_r + 1'b1) == kmax_r);
    e_last     = (ctr_pkg::TOTAL_W'(e_r + 1'b1) == total_r);
    dot_done   = (dot_i_r >= vlen_r) && !d1_v_r && !d2_v_r;
    scan_done  = (scan_i_r >= total_r) && !scan_v_r;
    eligible   = (round_r == '0) || ($signed(sc_rd) < last_score_r)
               || (($signed(sc_rd) == last_score_r) && (scan_didx_r > last_idx_r));
    better     = !found_r || ($signed(sc_rd) > best_score_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vlen_r       <= 7'd64;
      topk_r       <= 5'd8;
      thr_r        <= 32'sd167772;
      floor_r      <= 16'd9830;
      ven_r        <= 1'b0;
      pos_r        <= '0;
      kind_r       <= 1'b0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      d1_v_r       <= 1'b0;
      d2_v_r       <= 1'b0;
      scan_v_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ctr_pkg::REG_VLEN:  vlen_r  <= cfg_data[ctr_pkg::POS_W-1:0];
          ctr_pkg::REG_TOPK:  topk_r  <= cfg_data[ctr_pkg::TOPK_W-1:0];
          ctr_pkg::REG_THR:   thr_r   <= $signed(cfg_data);
          ctr_pkg::REG_FLOOR: floor_r <= cfg_data[ctr_pkg::CONF_W-1:0];
          ctr_pkg::REG_VEN:   ven_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_idx_r   <= '0;
            out_score_r <= '0;
            out_conf_r  <= '0;
            out_rank_r  <= '0;
            out_end_r   <= 1'b1;
            unique case (in_op)
              ctr_pkg::OP_CLEAR: begin
                total_r      <= '0;
                pos_r        <= '0;
                kind_r       <= 1'b0;
                out_valid_r  <= 1'b1;
                out_status_r <= ctr_pkg::ST_CLEARED;
              end
              ctr_pkg::OP_STORE, ctr_pkg::OP_QUERY: begin
                kind_r <= in_op[0];
                if (!in_last) begin
                  pos_r   <= pos_inc;
                  sqacc_r <= sum_nxt;
                end else begin
                  pos_r <= '0;
                  if (len_bad) begin
                    out_valid_r  <= 1'b1;
                    out_status_r <= ctr_pkg::ST_LEN_ERR;
                  end else if (in_op == ctr_pkg::OP_STORE) begin
                    out_valid_r <= 1'b1;
                    if (full) begin
                      out_status_r <= ctr_pkg::ST_FULL;
                    end else begin
                      out_status_r <= ctr_pkg::ST_STORED;
                      out_idx_r    <= ctr_pkg::IDX_W'(total_r[ctr_pkg::ENTRY_AW-1:0]);
                      total_r      <= total_r + 1'b1;
                    end
                  end else begin
                    nq_r         <= sum_nxt;
                    pend_valid_r <= 1'b0;
                    cnt_r        <= '0;
                    e_r          <= '0;
                    sq_x_r       <= {1'b0, sum_nxt, 20'd0};
                    sq_rem_r     <= '0;
                    sq_root_r    <= '0;
                    step_r       <= ctr_pkg::SQRT_STEPS;
                    state_r      <= S_RQ;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RQ, S_RK: begin
          sq_x_r    <= sq_x_r << 2;
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          step_r    <= step_r - 1'b1;
          if (step_r == '0) begin
            if (state_r == S_RQ) begin
              rq_r <= sq_root_nxt;
              if (total_r == '0) begin
                round_r <= '0;
                kmax_r  <= kmax_nxt;
                state_r <= S_FIN;
              end else begin
                dot_i_r <= '0;
                dot_r   <= '0;
                state_r <= S_DOT;
              end
            end else begin
              mu_acc_r <= '0;
              mu_a_r   <= ctr_pkg::MUL_W'(rq_r);
              mu_b_r   <= sq_root_nxt;
              step_r   <= ctr_pkg::DMUL_STEPS;
              state_r  <= S_MUL;
            end
          end
        end
        S_DOT: begin
          if (dot_i_r < vlen_r) begin
            d1_v_r  <= 1'b1;
            dot_i_r <= dot_i_r + 1'b1;
          end else begin
            d1_v_r <= 1'b0;
          end
          d2_v_r <= d1_v_r;
          if (d1_v_r) begin
            prod_r <= prod_nxt;
          end
          if (d2_v_r) begin
            dot_r <= dot_r + ctr_pkg::DOT_W'(prod_r);
          end
          if (dot_done) begin
            neg_r  <= dot_r[ctr_pkg::DOT_W-1] ^ wgt_rd[ctr_pkg::WGT_W-1];
            wabs_r <= wabs_nxt;
            if ((nq_r == '0) || (norm_rd == '0)) begin
              score_r <= '0;
              state_r <= S_WR;
            end else begin
              sq_x_r    <= {1'b0, norm_rd, 20'd0};
              sq_rem_r  <= '0;
              sq_root_r <= '0;
              step_r    <= ctr_pkg::SQRT_STEPS;
              state_r   <= S_RK;
            end
          end
        end
        S_MUL, S_WMUL: begin
          mu_acc_r <= mu_acc_nxt;
          mu_a_r   <= mu_a_r << 1;
          mu_b_r   <= mu_b_r >> 1;
          step_r   <= step_r - 1'b1;
          if (step_r == '0) begin
            if (state_r == S_MUL) begin
              d_r     <= mu_acc_nxt;
              dv_n_r  <= {dot_mag, 44'd0};
              dv_r_r  <= '0;
              dv_q_r  <= '0;
              step_r  <= ctr_pkg::DIV_STEPS;
              state_r <= S_DIV;
            end else begin
              score_r <= score_nxt;
              state_r <= S_WR;
            end
          end
        end
        S_DIV: begin
          dv_n_r <= dv_n_r << 1;
          dv_r_r <= dv_r_nxt;
          dv_q_r <= dv_q_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            mu_acc_r <= '0;
            mu_a_r   <= ctr_pkg::MUL_W'(q_clamp);
            mu_b_r   <= ctr_pkg::ROOT_W'(wabs_r);
            step_r   <= ctr_pkg::WMUL_STEPS;
            state_r  <= S_WMUL;
          end
        end
        S_WR: begin
          e_r <= e_r + 1'b1;
          if (e_last) begin
            round_r  <= '0;
            kmax_r   <= kmax_nxt;
            scan_i_r <= '0;
            scan_v_r <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= (kmax_nxt == '0) ? S_FIN : S_SCAN;
          end else begin
            dot_i_r <= '0;
            dot_r   <= '0;
            state_r <= S_DOT;
          end
        end
        S_SCAN: begin
          if (scan_i_r < total_r) begin
            scan_v_r    <= 1'b1;
            scan_didx_r <= scan_i_r[ctr_pkg::ENTRY_AW-1:0];
            scan_i_r    <= scan_i_r + 1'b1;
          end else begin
            scan_v_r <= 1'b0;
          end
          if (scan_v_r && eligible && better) begin
            found_r      <= 1'b1;
            best_r       <= scan_didx_r;
            best_score_r <= $signed(sc_rd);
          end
          if (scan_done) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (!found_r || (best_score_r < thr_r)) begin
            state_r <= S_FIN;
          end else begin
            last_idx_r   <= best_r;
            last_score_r <= best_score_r;
            state_r      <= S_CONF;
          end
        end
        S_CONF: begin
          state_r <= S_HIT;
        end
        S_HIT: begin
          if (!(ven_r && (conf_rd < floor_r)) && pend_valid_r && !slot_free) begin
            state_r <= S_HIT;
          end else begin
            if (!(ven_r && (conf_rd < floor_r))) begin
              if (pend_valid_r) begin
                out_valid_r  <= 1'b1;
                out_status_r <= ctr_pkg::ST_HIT;
                out_idx_r    <= pend_idx_r;
                out_score_r  <= pend_score_r;
                out_conf_r   <= pend_conf_r;
                out_rank_r   <= pend_rank_r;
                out_end_r    <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_idx_r   <= ctr_pkg::IDX_W'(best_r);
              pend_score_r <= best_score_r;
              pend_conf_r  <= conf_rd;
              pend_rank_r  <= cnt_r[ctr_pkg::RANK_W-1:0];
              cnt_r        <= cnt_r + 1'b1;
            end
            round_r <= round_r + 1'b1;
            if (round_last) begin
              state_r <= S_FIN;
            end else begin
              scan_i_r <= '0;
              scan_v_r <= 1'b0;
              found_r  <= 1'b0;
              state_r  <= S_SCAN;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_end_r    <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
            if (pend_valid_r) begin
              out_status_r <= ctr_pkg::ST_HIT;
              out_idx_r    <= pend_idx_r;
              out_score_r  <= pend_score_r;
              out_conf_r   <= pend_conf_r;
              out_rank_r   <= pend_rank_r;
            end else begin
              out_status_r <= ctr_pkg::ST_NO_HIT;
              out_idx_r    <= '0;
              out_score_r  <= '0;
              out_conf_r   <= '0;
              out_rank_r   <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ctr_ram #(.WIDTH(ctr_pkg::ELEMENT_BITS), .DEPTH(ctr_pkg::KEY_DEPTH)) u_key_ram (
    .clk(clk), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(in_element),
    .rd_addr(key_raddr), .rd_data(key_rd)
  );

  ctr_ram #(.WIDTH(ctr_pkg::ELEMENT_BITS), .DEPTH(ctr_pkg::MAX_LENGTH)) u_query_ram (
    .clk(clk), .wr_en(qb_we), .wr_addr(qb_waddr), .wr_data(in_element),
    .rd_addr(qb_raddr), .rd_data(qb_rd)
  );

  ctr_ram #(.WIDTH(ctr_pkg::WGT_W), .DEPTH(ctr_pkg::ENTRIES)) u_weight_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(in_weight),
    .rd_addr(ent_raddr), .rd_data(wgt_rd)
  );

  ctr_ram #(.WIDTH(ctr_pkg::CONF_W), .DEPTH(ctr_pkg::ENTRIES)) u_conf_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(in_confidence),
    .rd_addr(conf_raddr), .rd_data(conf_rd)
  );

  ctr_ram #(.WIDTH(ctr_pkg::NORM_W), .DEPTH(ctr_pkg::ENTRIES)) u_norm_ram (
    .clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(sum_nxt),
    .rd_addr(ent_raddr), .rd_data(norm_rd)
  );

  ctr_ram #(.WIDTH(ctr_pkg::SCORE_W), .DEPTH(ctr_pkg::ENTRIES)) u_score_ram (
    .clk(clk), .wr_en(sc_we), .wr_addr(ent_raddr), .wr_data(score_r),
    .rd_addr(sc_raddr), .rd_data(sc_rd)
  );

endmodule
